/* hdl/rlqm_pkg.sv */
package rlqm_pkg;

  typedef enum logic [1:0] {
    MODE_OK   = 2'd0,
    MODE_FAIL = 2'd1,
    MODE_RSSI = 2'd2,
    MODE_TICK = 2'd3
  } mode_t;

  localparam int CfgIndexW = 8;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIndexW-1:0] CFG_RSSI_OFFSET    = 8'd0;
  localparam logic [CfgIndexW-1:0] CFG_LINK_LOST_THR  = 8'd1;

  localparam logic [15:0] RSSI_OFFSET_RESET   = 16'h0210;
  localparam logic [7:0]  LINK_LOST_THR_RESET = 8'h35;
  localparam logic [7:0]  RUN_MAX_FULL        = 8'hFF;
  localparam logic [7:0]  RUN_FORCED          = 8'hFA;

  localparam int InDataW  = 8;
  localparam int OutDataW = 64;

  typedef struct packed {
    mode_t      mode;
    logic       counted;
    logic [4:0] rssi_sample;
  } event_t;

  typedef struct packed {
    logic [7:0]  good_frames_last_second;
    logic [7:0]  bad_frames_last_second;
    logic [7:0]  longest_run_last_second;
    logic [7:0]  rssi_average;
    logic [4:0]  rssi_latest;
    logic [15:0] uptime_seconds;
    logic [7:0]  failure_run;
    logic        link_lost;
    logic        radio_reset_request;
  } result_t;

endpackage

/* hdl/rlqm_stats.sv */
module rlqm_stats (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  rlqm_pkg::event_t  evt,
  input  logic [15:0]       rssi_offset,
  input  logic [7:0]        link_lost_threshold,
  output rlqm_pkg::result_t result
);
  import rlqm_pkg::*;

  logic [7:0]  good_running, good_running_next;
  logic [7:0]  bad_running, bad_running_next;
  logic [7:0]  run_length, run_length_next;
  logic [7:0]  run_maximum, run_maximum_next;
  logic [15:0] rssi_accumulator, rssi_accumulator_next;
  logic [15:0] uptime_count, uptime_count_next;
  logic [7:0]  good_snapshot, good_snapshot_next;
  logic [7:0]  bad_snapshot, bad_snapshot_next;
  logic [7:0]  run_max_snapshot, run_max_snapshot_next;
  logic [7:0]  rssi_mean_reg, rssi_mean_reg_next;
  logic [4:0]  rssi_last_reg, rssi_last_reg_next;
  logic        reset_req;

  logic [16:0] diff;
  logic [16:0] diff_mag;
  logic [13:0] quot;
  logic [7:0]  mean;
  logic [7:0]  run_inc;

  // Average rounds toward zero, so a negative difference is divided as a magnitude.
  always_comb begin
    diff     = {1'b0, rssi_accumulator} - {1'b0, rssi_offset};
    diff_mag = diff[16] ? (17'd0 - diff) : diff;
    quot     = diff_mag[16:3];
    mean     = diff[16] ? (8'd0 - quot[7:0]) : quot[7:0];
  end

  always_comb begin
    good_running_next     = good_running;
    bad_running_next      = bad_running;
    run_length_next       = run_length;
    run_maximum_next      = run_maximum;
    rssi_accumulator_next = rssi_accumulator;
    uptime_count_next     = uptime_count;
    good_snapshot_next    = good_snapshot;
    bad_snapshot_next     = bad_snapshot;
    run_max_snapshot_next = run_max_snapshot;
    rssi_mean_reg_next    = rssi_mean_reg;
    rssi_last_reg_next    = rssi_last_reg;
    reset_req             = 1'b0;
    run_inc               = run_length + 8'd1;

    case (evt.mode)
      MODE_OK: begin
        if (evt.counted) begin
          good_running_next = good_running + 8'd1;
          run_length_next   = 8'd0;
        end
      end
      MODE_FAIL: begin
        if (evt.counted) begin
          bad_running_next = bad_running + 8'd1;
          run_length_next  = run_inc;
          if (run_length >= run_maximum) begin
            run_maximum_next = run_inc;
          end
          if (run_maximum_next == RUN_MAX_FULL) begin
            run_length_next = RUN_FORCED;
          end
        end
      end
      MODE_RSSI: begin
        rssi_last_reg_next    = evt.rssi_sample;
        rssi_accumulator_next = rssi_accumulator + {11'd0, evt.rssi_sample};
      end
      MODE_TICK: begin
        rssi_mean_reg_next    = mean;
        rssi_accumulator_next = 16'd0;
        uptime_count_next     = uptime_count + 16'd1;
        good_snapshot_next    = good_running;
        good_running_next     = 8'd0;
        bad_snapshot_next     = bad_running;
        bad_running_next      = 8'd0;
        run_max_snapshot_next = run_maximum;
        run_maximum_next      = 8'd0;
        reset_req             = run_length > link_lost_threshold;
      end
      default: begin
      end
    endcase

    result.good_frames_last_second = good_snapshot_next;
    result.bad_frames_last_second  = bad_snapshot_next;
    result.longest_run_last_second = run_max_snapshot_next;
    result.rssi_average            = rssi_mean_reg_next;
    result.rssi_latest             = rssi_last_reg_next;
    result.uptime_seconds          = uptime_count_next;
    result.failure_run             = run_length_next;
    result.link_lost               = run_length_next > link_lost_threshold;
    result.radio_reset_request     = reset_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      good_running     <= '0;
      bad_running      <= '0;
      run_length       <= '0;
      run_maximum      <= '0;
      rssi_accumulator <= '0;
      uptime_count     <= '0;
      good_snapshot    <= '0;
      bad_snapshot     <= '0;
      run_max_snapshot <= '0;
      rssi_mean_reg    <= '0;
      rssi_last_reg    <= '0;
    end else if (step) begin
      good_running     <= good_running_next;
      bad_running      <= bad_running_next;
      run_length       <= run_length_next;
      run_maximum      <= run_maximum_next;
      rssi_accumulator <= rssi_accumulator_next;
      uptime_count     <= uptime_count_next;
      good_snapshot    <= good_snapshot_next;
      bad_snapshot     <= bad_snapshot_next;
      run_max_snapshot <= run_max_snapshot_next;
      rssi_mean_reg    <= rssi_mean_reg_next;
      rssi_last_reg    <= rssi_last_reg_next;
    end
  end

endmodule

/* hdl/radio_link_quality_monitor.sv */
// An accepted item is held in the input register, and its result is then
// registered in the output register. Throughput: one item per cycle while
// the output is not stalled; the statistics update between the two registers.
// Reset (rst, synchronous, active high) clears all statistics, empties both
// stages and restores the offset to 528 and the threshold to 53.
module radio_link_quality_monitor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] counted, [5:1] rssi_sample, [7:6] zero
  input  logic [rlqm_pkg::InDataW-1:0]        s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] good_frames_last_second, [15:8] bad_frames_last_second,
  // [23:16] longest_run_last_second, [31:24] rssi_average,
  // [36:32] rssi_latest, [52:37] uptime_seconds, [60:53] failure_run,
  // [61] link_lost, [62] radio_reset_request, [63] zero
  output logic [rlqm_pkg::OutDataW-1:0]       m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rlqm_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [rlqm_pkg::CfgDataW-1:0]       cfg_data
);
  import rlqm_pkg::*;

  logic        in_valid;
  event_t      in_event;
  logic        out_valid;
  result_t     out_result;
  result_t     result;
  logic        advance;
  logic [15:0] rssi_offset;
  logic [7:0]  link_lost_threshold;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rssi_offset         <= RSSI_OFFSET_RESET;
      link_lost_threshold <= LINK_LOST_THR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RSSI_OFFSET:   rssi_offset         <= cfg_data;
        CFG_LINK_LOST_THR: link_lost_threshold <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_event.mode        <= mode_t'(s_axis_tuser);
      in_event.counted     <= s_axis_tdata[0];
      in_event.rssi_sample <= s_axis_tdata[5:1];
    end
  end

  rlqm_stats u_stats (
    .clk                 (clk),
    .rst                 (rst),
    .step                (advance),
    .evt                 (in_event),
    .rssi_offset         (rssi_offset),
    .link_lost_threshold (link_lost_threshold),
    .result              (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0,
                          out_result.radio_reset_request,
                          out_result.link_lost,
                          out_result.failure_run,
                          out_result.uptime_seconds,
                          out_result.rssi_latest,
                          out_result.rssi_average,
                          out_result.longest_run_last_second,
                          out_result.bad_frames_last_second,
                          out_result.good_frames_last_second};

endmodule
